// ===== rtl/kmer_diagonal_finder_assert.svh =====
// ---------------------------------------------------------------------------
// kmer_diagonal_finder assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef KMER_DIAGONAL_FINDER_ASSERT_SVH
`define KMER_DIAGONAL_FINDER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define KDF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kdf check failed");
// next-cycle implication
`define KDF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kdf check failed");
`else
`define KDF_ASSERT_IMP(lbl, ante, cons)
`define KDF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/kdf_pkg.sv =====
// ---------------------------------------------------------------------------
// kdf_pkg
// Shared constants, state type and base decoding for the k-mer diagonal finder.
// ---------------------------------------------------------------------------
package kdf_pkg;

  localparam int MAX_SEQ_LEN_DEF = 512;
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int KLEN_W          = 5;
  localparam int KLEN_RESET      = 5;
  localparam int BASE_W          = 8;
  localparam int KMER_W          = 32;
  localparam int CNT_W           = 10;
  localparam int COUNT_MAX       = 1023;
  localparam int DIAG_DIV        = 20;
  localparam int DIV_R_W         = 5;
  localparam int BEST_W          = 10;
  localparam int OUT_TD_W        = 16;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR_TAB,
    ST_CLR_CNT,
    ST_TAB_RD,
    ST_TAB_CHK,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_SCAN_INIT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_OUT
  } kdf_state_t;

  function automatic logic is_ambig(input logic [BASE_W-1:0] c);
    logic a;
    case (c)
      "A", "C", "G", "T", "U", "a", "c", "g", "t", "u": a = 1'b0;
      default: a = 1'b1;
    endcase
    return a;
  endfunction

  function automatic logic [1:0] code2(input logic [BASE_W-1:0] c);
    logic [1:0] v;
    case (c)
      "C", "c": v = 2'd1;
      "G", "g": v = 2'd2;
      "T", "t", "U", "u": v = 2'd3;
      default: v = 2'd0;
    endcase
    return v;
  endfunction

  // zero acts as one, anything above sixteen as sixteen
  function automatic logic [KLEN_W-1:0] eff_k(input logic [KLEN_W-1:0] k);
    logic [KLEN_W-1:0] e;
    if (k == '0) e = KLEN_W'(1);
    else if (k > KLEN_W'(16)) e = KLEN_W'(16);
    else e = k;
    return e;
  endfunction

  function automatic logic [KMER_W-1:0] kmask(input logic [KLEN_W-1:0] k);
    logic [KMER_W-1:0] m;
    for (int i = 0; i < KMER_W / 2; i++) begin
      m[2*i +: 2] = (KLEN_W'(i) < k) ? 2'b11 : 2'b00;
    end
    return m;
  endfunction

endpackage

// ===== rtl/kdf_ram.sv =====
// ---------------------------------------------------------------------------
// kdf_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module kdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/kmer_diagonal_finder.sv =====
// ---------------------------------------------------------------------------
// kmer_diagonal_finder
// Hashes reference k-mers into a linear-probed table, counts query seed hits
// per diagonal and at query end reports the best if just one is good, else all ones.
// ---------------------------------------------------------------------------
//  channel | dir | fields
//  in_     | in  | tdata: base_char[7:0]; tuser: op[0], first_base[1]; tlast: last_base
//  out_    | out | tdata: best_diagonal[9:0], zero pad to 16
//  cfg_    | in  | wdata: kmer_length[4:0], written on cfg_we
//
//  Reset sweeps both memories; no beat is taken during the sweep.
//  A first reference base adds a table sweep; a first query base adds a count sweep.
//  Each stored k-mer probes the table slot by slot (table read port, then check);
//  each counted query hit adds a count read-modify-write.
//  A last query base starts the diagonal scan.
//  The result sits in an output register; only a new scan waits on a held beat.
// ---------------------------------------------------------------------------
module kmer_diagonal_finder #(
  parameter int MAX_SEQ_LEN = kdf_pkg::MAX_SEQ_LEN_DEF,
  parameter int TABLE_DEPTH = kdf_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [kdf_pkg::BASE_W-1:0]    in_tdata,   // base_char
  input  logic [1:0]                    in_tuser,   // op, first_base
  input  logic                          in_tlast,   // last_base
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [kdf_pkg::OUT_TD_W-1:0]  out_tdata,  // best_diagonal, pad
  input  logic                          cfg_we,
  input  logic [kdf_pkg::KLEN_W-1:0]    cfg_wdata   // kmer_length
);
  import kdf_pkg::*;

  `include "kmer_diagonal_finder_assert.svh"

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int SU_W   = $clog2(TABLE_DEPTH + 1);
  localparam int LEN_W  = $clog2(MAX_SEQ_LEN + 1);
  localparam int QP_W   = $clog2(2 * MAX_SEQ_LEN);
  localparam int DG_W   = $clog2(MAX_SEQ_LEN);
  localparam int SD_W   = QP_W + 2;
  localparam int MW     = LEN_W + 6;
  localparam int CE_W   = LEN_W + 1;
  localparam int SW_N   = (TABLE_DEPTH > MAX_SEQ_LEN) ? TABLE_DEPTH : MAX_SEQ_LEN;
  localparam int CL_W   = $clog2(SW_N);
  localparam int TW_W   = 1 + KMER_W + LEN_W;
  localparam int QP_MAX = 2 * MAX_SEQ_LEN - 1;

  kdf_state_t state_r, state_nxt;

  logic [CL_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic [KLEN_W-1:0] klen_r;
  logic [KMER_W-1:0] ref_km_r, ref_km_nxt, ref_amb_r, ref_amb_nxt;
  logic [KMER_W-1:0] q_km_r, q_km_nxt, q_amb_r, q_amb_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt, lq_r, lq_nxt;
  logic [DIV_R_W-1:0] lr_r, lr_nxt;
  logic [QP_W-1:0]   qpos_r, qpos_nxt;
  logic [SU_W-1:0]   su_r, su_nxt;
  logic              is_q_r, is_q_nxt, probe_go_r, probe_go_nxt, scan_go_r, scan_go_nxt;
  logic [KMER_W-1:0] probe_km_r, probe_km_nxt;
  logic [LEN_W-1:0]  ins_pos_r, ins_pos_nxt;
  logic [SD_W-1:0]   dbase_r, dbase_nxt;
  logic [AW-1:0]     probe_j_r, probe_j_nxt;
  logic [SU_W-1:0]   probe_n_r, probe_n_nxt;
  logic [DG_W-1:0]   cnt_addr_r, cnt_addr_nxt;
  logic [DG_W:0]     scan_d_r, scan_d_nxt;
  logic [LEN_W-1:0]  sl_r, sl_nxt, sq_r, sq_nxt;
  logic [DIV_R_W-1:0] sr_r, sr_nxt;
  logic [1:0]        good_r, good_nxt;
  logic [DG_W-1:0]   best_r, best_nxt;
  logic [CNT_W-1:0]  bc_r, bc_nxt;
  logic              have_r, have_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BEST_W-1:0] out_data_r, out_data_nxt;

  // memory ports
  logic              tab_we;
  logic [AW-1:0]     tab_waddr, tab_raddr;
  logic [TW_W-1:0]   tab_wdata, tab_rdata;
  logic              cnt_we;
  logic [DG_W-1:0]   cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;

  // decode of the accepted beat
  logic              in_fire, b_op, b_first, b_last, ins_go, cnt_go, acc_probe;
  logic [1:0]        amb2;
  logic [KLEN_W-1:0] k_eff;
  logic [KMER_W-1:0] kmsk, new_km, hfold_src;
  logic [AW-1:0]     hfold, hash_j;
  logic [LEN_W-1:0]  len_e;
  logic [QP_W-1:0]   qp_e;
  logic [SU_W-1:0]   su_e;

  // table entry fields and derived values
  logic              t_valid, t_match, diag_ok;
  logic [KMER_W-1:0] t_kmer;
  logic [LEN_W-1:0]  t_pos;
  logic [SD_W-1:0]   diag;
  logic              clr_end, scan_cont, out_ld;
  logic [AW-1:0]     j_inc;
  logic [LEN_W+KLEN_W-1:0] kq;
  logic signed [MW-1:0]    minm, min1;
  logic              c_good, c_best;
  kdf_state_t        post_st, fin_st;

  assign k_eff   = eff_k(klen_r);
  assign kmsk    = kmask(k_eff);
  assign in_fire = in_tvalid && in_tready;
  assign b_op    = in_tuser[0];
  assign b_first = in_tuser[1];
  assign b_last  = in_tlast;
  assign amb2    = is_ambig(in_tdata) ? 2'b11 : 2'b00;
  assign len_e   = b_first ? '0 : len_r;
  assign qp_e    = b_first ? '0 : qpos_r;
  assign su_e    = b_first ? '0 : su_r;

  assign t_valid = tab_rdata[TW_W-1];
  assign t_kmer  = tab_rdata[LEN_W +: KMER_W];
  assign t_pos   = tab_rdata[LEN_W-1:0];
  assign t_match = (t_kmer == probe_km_r);
  assign diag    = SD_W'(t_pos) + dbase_r;
  assign diag_ok = !diag[SD_W-1] && (diag[SD_W-2:0] < (SD_W-1)'(MAX_SEQ_LEN));
  assign j_inc   = (probe_j_r == AW'(TABLE_DEPTH - 1)) ? '0 : probe_j_r + AW'(1);

  // fold the k-mer onto the table index, then one conditional subtract
  always_comb begin
    hfold_src = b_op ? q_km_nxt : ref_km_nxt;
    hfold = '0;
    for (int i = 0; i < KMER_W; i++) begin
      hfold[i % AW] = hfold[i % AW] ^ hfold_src[i];
    end
    if ({1'b0, hfold} >= (AW+1)'(TABLE_DEPTH)) hash_j = AW'({1'b0, hfold} - (AW+1)'(TABLE_DEPTH));
    else hash_j = hfold;
  end

  assign new_km    = hfold_src;
  assign acc_probe = b_op ? cnt_go : ins_go;

  // sweep end for the current clearing state
  always_comb begin
    unique case (state_r)
      ST_INIT:    clr_end = (clr_idx_r == CL_W'(SW_N - 1));
      ST_CLR_TAB: clr_end = (clr_idx_r == CL_W'(TABLE_DEPTH - 1));
      ST_CLR_CNT: clr_end = (clr_idx_r == CL_W'(MAX_SEQ_LEN - 1));
      default:    clr_end = 1'b0;
    endcase
  end

  assign post_st = probe_go_r ? ST_TAB_RD : (scan_go_r ? ST_SCAN_INIT : ST_IDLE);
  assign fin_st  = scan_go_r ? ST_SCAN_INIT : ST_IDLE;
  assign scan_cont = (CE_W'(scan_d_r) + CE_W'(k_eff) <= CE_W'(len_r)) &&
                     (scan_d_r < (DG_W+1)'(MAX_SEQ_LEN));
  assign out_ld    = !out_valid_r || out_tready;

  // minimum hit count for the diagonal under check
  assign kq     = LEN_W'(k_eff) * sq_r;
  assign minm   = MW'(sl_r) - MW'(k_eff) + MW'(1) - MW'(kq);
  assign min1   = (minm < MW'(1)) ? MW'(1) : minm;
  assign c_good = $signed(MW'(cnt_rdata)) >= min1;
  assign c_best = !have_r || (cnt_rdata > bc_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:    if (clr_end) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          if (b_first) state_nxt = b_op ? ST_CLR_CNT : ST_CLR_TAB;
          else if (acc_probe) state_nxt = ST_TAB_RD;
          else if (b_op && b_last) state_nxt = ST_SCAN_INIT;
          else state_nxt = ST_IDLE;
        end
      end
      ST_CLR_TAB, ST_CLR_CNT: if (clr_end) state_nxt = post_st;
      ST_TAB_RD:  state_nxt = ST_TAB_CHK;
      ST_TAB_CHK: begin
        if (!is_q_r) state_nxt = t_valid ? ST_TAB_RD : ST_IDLE;
        else if (!t_valid) state_nxt = fin_st;
        else if (t_match && diag_ok) state_nxt = ST_CNT_RD;
        else if (probe_n_r + SU_W'(1) == SU_W'(TABLE_DEPTH)) state_nxt = fin_st;
        else state_nxt = ST_TAB_RD;
      end
      ST_CNT_RD:  state_nxt = ST_CNT_WR;
      ST_CNT_WR:  state_nxt = (probe_n_r == SU_W'(TABLE_DEPTH)) ? fin_st : ST_TAB_RD;
      ST_SCAN_INIT: state_nxt = ST_SCAN_RD;
      ST_SCAN_RD: state_nxt = scan_cont ? ST_SCAN_CHK : ST_OUT;
      ST_SCAN_CHK: state_nxt = ST_SCAN_RD;
      ST_OUT:     if (out_ld) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    tab_we    = 1'b0;
    tab_waddr = clr_idx_r[AW-1:0];
    tab_wdata = '0;
    tab_raddr = probe_j_r;
    cnt_we    = 1'b0;
    cnt_waddr = clr_idx_r[DG_W-1:0];
    cnt_wdata = '0;
    cnt_raddr = cnt_addr_r;
    unique case (state_r)
      ST_INIT: begin
        tab_we = ({1'b0, clr_idx_r} < (CL_W+1)'(TABLE_DEPTH));
        cnt_we = ({1'b0, clr_idx_r} < (CL_W+1)'(MAX_SEQ_LEN));
      end
      ST_CLR_TAB: tab_we = 1'b1;
      ST_CLR_CNT: cnt_we = 1'b1;
      ST_TAB_CHK: begin
        if (!is_q_r && !t_valid) begin
          tab_we    = 1'b1;
          tab_waddr = probe_j_r;
          tab_wdata = {1'b1, probe_km_r, ins_pos_r};
        end
      end
      ST_CNT_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = cnt_addr_r;
        cnt_wdata = (cnt_rdata < CNT_W'(COUNT_MAX)) ? cnt_rdata + CNT_W'(1) : cnt_rdata;
      end
      ST_SCAN_RD: cnt_raddr = scan_d_r[DG_W-1:0];
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    clr_idx_nxt  = clr_end ? '0 : clr_idx_r;
    ref_km_nxt   = ref_km_r;
    ref_amb_nxt  = ref_amb_r;
    q_km_nxt     = q_km_r;
    q_amb_nxt    = q_amb_r;
    len_nxt      = len_r;
    lq_nxt       = lq_r;
    lr_nxt       = lr_r;
    qpos_nxt     = qpos_r;
    su_nxt       = su_r;
    is_q_nxt     = is_q_r;
    probe_go_nxt = probe_go_r;
    scan_go_nxt  = scan_go_r;
    probe_km_nxt = probe_km_r;
    ins_pos_nxt  = ins_pos_r;
    dbase_nxt    = dbase_r;
    probe_j_nxt  = probe_j_r;
    probe_n_nxt  = probe_n_r;
    cnt_addr_nxt = cnt_addr_r;
    scan_d_nxt   = scan_d_r;
    sl_nxt       = sl_r;
    sq_nxt       = sq_r;
    sr_nxt       = sr_r;
    good_nxt     = good_r;
    best_nxt     = best_r;
    bc_nxt       = bc_r;
    have_nxt     = have_r;
    ins_go       = 1'b0;
    cnt_go       = 1'b0;
    out_valid_nxt = (out_valid_r && out_tready) ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;

    // shift registers advance only on an accepted beat
    if (in_fire) begin
      if (b_op) begin
        q_amb_nxt = (((b_first ? kmsk : q_amb_r) << 2) | KMER_W'(amb2)) & kmsk;
        q_km_nxt  = (((b_first ? '0 : q_km_r) << 2) | KMER_W'(~code2(in_tdata))) & kmsk;
        cnt_go    = (q_amb_nxt == '0) && (QP_W'(qp_e) + QP_W'(1) >= QP_W'(k_eff));
      end else if (len_e < LEN_W'(MAX_SEQ_LEN)) begin
        ref_amb_nxt = (((b_first ? kmsk : ref_amb_r) << 2) | KMER_W'(amb2)) & kmsk;
        ref_km_nxt  = (((b_first ? '0 : ref_km_r) << 2) | KMER_W'(code2(in_tdata))) & kmsk;
        ins_go      = (ref_amb_nxt == '0) && (CE_W'(len_e) + CE_W'(1) >= CE_W'(k_eff)) &&
                      (su_e < SU_W'(TABLE_DEPTH));
      end else begin
        ref_amb_nxt = b_first ? kmsk : ref_amb_r;
        ref_km_nxt  = b_first ? '0 : ref_km_r;
      end
    end

    unique case (state_r)
      ST_INIT, ST_CLR_TAB, ST_CLR_CNT: begin
        if (!clr_end) clr_idx_nxt = clr_idx_r + CL_W'(1);
      end
      ST_IDLE: begin
        if (!in_fire) begin
          ref_km_nxt  = ref_km_r;
          ref_amb_nxt = ref_amb_r;
          q_km_nxt    = q_km_r;
          q_amb_nxt   = q_amb_r;
        end else begin
          is_q_nxt     = b_op;
          probe_go_nxt = acc_probe;
          scan_go_nxt  = b_op && b_last;
          probe_km_nxt = new_km;
          probe_j_nxt  = hash_j;
          probe_n_nxt  = '0;
          if (b_op) begin
            ref_km_nxt  = ref_km_r;
            ref_amb_nxt = ref_amb_r;
            qpos_nxt    = (qp_e < QP_W'(QP_MAX)) ? qp_e + QP_W'(1) : qp_e;
            dbase_nxt   = SD_W'(k_eff) - SD_W'(2) - SD_W'(qp_e);
          end else begin
            q_km_nxt    = q_km_r;
            q_amb_nxt   = q_amb_r;
            su_nxt      = su_e;
            len_nxt     = len_e;
            lq_nxt      = b_first ? '0 : lq_r;
            lr_nxt      = b_first ? '0 : lr_r;
            ins_pos_nxt = len_e + LEN_W'(2) - LEN_W'(k_eff);
            if (len_e < LEN_W'(MAX_SEQ_LEN)) begin
              len_nxt = len_e + LEN_W'(1);
              // keep len / 20 and len % 20 alongside the length
              if (lr_nxt == DIV_R_W'(DIAG_DIV - 1)) begin
                lr_nxt = '0;
                lq_nxt = lq_nxt + LEN_W'(1);
              end else begin
                lr_nxt = lr_nxt + DIV_R_W'(1);
              end
            end
          end
        end
      end
      ST_TAB_CHK: begin
        probe_j_nxt  = j_inc;
        probe_n_nxt  = probe_n_r + SU_W'(1);
        cnt_addr_nxt = diag[DG_W-1:0];
        if (!is_q_r && !t_valid) su_nxt = su_r + SU_W'(1);
      end
      ST_SCAN_INIT: begin
        scan_d_nxt = '0;
        sl_nxt     = len_r;
        sq_nxt     = lq_r;
        sr_nxt     = lr_r;
        good_nxt   = '0;
        have_nxt   = 1'b0;
        bc_nxt     = '0;
        best_nxt   = '0;
      end
      ST_SCAN_CHK: begin
        if (c_good && good_r != 2'd2) good_nxt = good_r + 2'd1;
        if (c_best) begin
          have_nxt = 1'b1;
          bc_nxt   = cnt_rdata;
          best_nxt = scan_d_r[DG_W-1:0];
        end
        scan_d_nxt = scan_d_r + (DG_W+1)'(1);
        sl_nxt     = sl_r - LEN_W'(1);
        if (sr_r == '0) begin
          sr_nxt = DIV_R_W'(DIAG_DIV - 1);
          sq_nxt = sq_r - LEN_W'(1);
        end else begin
          sr_nxt = sr_r - DIV_R_W'(1);
        end
      end
      ST_OUT: begin
        if (out_ld) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = (good_r == 2'd1) ? BEST_W'(best_r) : '1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      clr_idx_r   <= '0;
      klen_r      <= KLEN_W'(KLEN_RESET);
      ref_km_r    <= '0;
      ref_amb_r   <= kmask(KLEN_W'(KLEN_RESET));
      q_km_r      <= '0;
      q_amb_r     <= kmask(KLEN_W'(KLEN_RESET));
      len_r       <= '0;
      lq_r        <= '0;
      lr_r        <= '0;
      qpos_r      <= '0;
      su_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      if (cfg_we) klen_r <= cfg_wdata;
      ref_km_r    <= ref_km_nxt;
      ref_amb_r   <= ref_amb_nxt;
      q_km_r      <= q_km_nxt;
      q_amb_r     <= q_amb_nxt;
      len_r       <= len_nxt;
      lq_r        <= lq_nxt;
      lr_r        <= lr_nxt;
      qpos_r      <= qpos_nxt;
      su_r        <= su_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_q_r     <= is_q_nxt;
    probe_go_r <= probe_go_nxt;
    scan_go_r  <= scan_go_nxt;
    probe_km_r <= probe_km_nxt;
    ins_pos_r  <= ins_pos_nxt;
    dbase_r    <= dbase_nxt;
    probe_j_r  <= probe_j_nxt;
    probe_n_r  <= probe_n_nxt;
    cnt_addr_r <= cnt_addr_nxt;
    scan_d_r   <= scan_d_nxt;
    sl_r       <= sl_nxt;
    sq_r       <= sq_nxt;
    sr_r       <= sr_nxt;
    good_r     <= good_nxt;
    best_r     <= best_nxt;
    bc_r       <= bc_nxt;
    have_r     <= have_nxt;
    out_data_r <= out_data_nxt;
  end

  kdf_ram #(.WIDTH(TW_W), .DEPTH(TABLE_DEPTH)) u_tab (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  kdf_ram #(.WIDTH(CNT_W), .DEPTH(MAX_SEQ_LEN)) u_cnt (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TD_W'(out_data_r);

  `KDF_ASSERT_IMP(a_ins_room, (state_r == ST_TAB_CHK) && !is_q_r, su_r < SU_W'(TABLE_DEPTH))
  `KDF_ASSERT_IMP(a_probe_bound, state_r == ST_TAB_RD, probe_n_r < SU_W'(TABLE_DEPTH))
  `KDF_ASSERT_NXT(a_out_load, (state_r == ST_OUT) && !out_valid_r, out_valid_r)

endmodule
